@@ hw/rtl/drfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drfr_pkg
// Shared types and constants of the delimited frame receiver: phase codes,
// marker characters, status codes and the payload length limits.
// ----------------------------------------------------------------------------
package drfr_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned LenW    = 12;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Longest frame the receiver honors; larger settings are clamped to this.
  localparam logic [LenW-1:0] MaxFrameBytes    = 12'd2048;
  localparam logic [LenW-1:0] PayloadLenReset  = 12'd1024;

  localparam logic [DataW-1:0] ChBang = 8'h21;  // '!'
  localparam logic [DataW-1:0] ChAmp  = 8'h26;  // '&'
  localparam logic [DataW-1:0] ChHash = 8'h23;  // '#'

  localparam logic [StatusW-1:0] StatusOk        = 2'd0;
  localparam logic [StatusW-1:0] StatusBadTrail1 = 2'd1;
  localparam logic [StatusW-1:0] StatusBadTrail2 = 2'd2;

  // Register index carried by paddr[2].
  localparam logic RegPayloadLength = 1'b0;

  typedef enum logic [2:0] {
    PH_HUNT1  = 3'd0,
    PH_HUNT2  = 3'd1,
    PH_DATA   = 3'd2,
    PH_TRAIL1 = 3'd3,
    PH_TRAIL2 = 3'd4
  } phase_e;

endpackage
`default_nettype wire

@@ hw/rtl/delimited_frame_receiver.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delimited_frame_receiver
// Byte-serial deframer for frames of the form "!&" <payload> "!#".
//
// Usage:
//   - Input channel (in_valid_i / in_ready_o / in_byte_i): one link byte per
//     request. Start marks and trailer '!' produce no result.
//   - Output channel (out_valid_o / out_ready_i): one result per payload byte
//     (is_end_o = 0) and one end-of-frame result (is_end_o = 1) carrying
//     frame_status_o: ok, bad first trailer byte or bad second trailer byte.
//   - APB port: register 0 at byte address 0 is payload_length (12 bits,
//     reset 1024, clamped to 2048). Write it only while the block is idle.
//   - Latency: a result shows in the cycle after acceptance unless stalled.
//   - Throughput: one byte per cycle while the skid register is empty; the
//     parse state and the byte counter update in the accepting cycle.
//   - Stall: results sit in an output register backed by a one-entry skid
//     register; the input keeps flowing while the consumer stalls until the
//     skid register fills, then in_ready_o drops.
//   - Reset: asynchronous, active low; hunt for a start mark, count cleared,
//     both result registers empty, payload_length back to 1024.
// ----------------------------------------------------------------------------
module delimited_frame_receiver (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input byte channel
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic [drfr_pkg::DataW-1:0]        in_byte_i,
  // result channel
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic [drfr_pkg::DataW-1:0]        out_data_o,
  output      logic                              is_end_o,
  output      logic [drfr_pkg::StatusW-1:0]      frame_status_o,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [drfr_pkg::ApbAddrW-1:0]     paddr,
  input  wire logic [drfr_pkg::ApbDataW-1:0]     pwdata,
  output      logic [drfr_pkg::ApbDataW-1:0]     prdata,
  output      logic                              pready
);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [drfr_pkg::LenW-1:0] len_q, len_d;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == drfr_pkg::RegPayloadLength);

  always_comb begin
    len_d = len_q;
    if (cfg_wr) begin
      len_d = pwdata[drfr_pkg::LenW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == drfr_pkg::RegPayloadLength) begin
      prdata = {{(drfr_pkg::ApbDataW-drfr_pkg::LenW){1'b0}}, len_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= drfr_pkg::PayloadLenReset;
    end else begin
      len_q <= len_d;
    end
  end

  // Clamp the programmed length to the frame limit.
  logic [drfr_pkg::LenW-1:0] eff_len;
  assign eff_len = (len_q > drfr_pkg::MaxFrameBytes) ? drfr_pkg::MaxFrameBytes : len_q;

  // --------------------------------------------------------------------------
  // Parse state
  // --------------------------------------------------------------------------
  drfr_pkg::phase_e          phase_q, phase_d;
  logic [drfr_pkg::LenW-1:0] count_q, count_d;
  logic [drfr_pkg::LenW-1:0] count_inc;
  logic                      in_fire;

  // Result produced by the accepted byte this cycle.
  logic                           res_valid;
  logic [drfr_pkg::DataW-1:0]     res_data;
  logic                           res_end;
  logic [drfr_pkg::StatusW-1:0]   res_status;

  assign in_fire   = in_valid_i && in_ready_o;
  assign count_inc = count_q + 12'd1;

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    res_valid  = 1'b0;
    res_data   = '0;
    res_end    = 1'b0;
    res_status = drfr_pkg::StatusOk;
    if (in_fire) begin
      case (phase_q)
        drfr_pkg::PH_HUNT2: begin
          // A wrong second start byte drops back without being rechecked.
          if (in_byte_i == drfr_pkg::ChAmp) begin
            count_d = '0;
            phase_d = (eff_len == '0) ? drfr_pkg::PH_TRAIL1 : drfr_pkg::PH_DATA;
          end else begin
            phase_d = drfr_pkg::PH_HUNT1;
          end
        end
        drfr_pkg::PH_DATA: begin
          count_d   = count_inc;
          res_valid = 1'b1;
          res_data  = in_byte_i;
          if (count_inc >= eff_len) begin
            phase_d = drfr_pkg::PH_TRAIL1;
          end
        end
        drfr_pkg::PH_TRAIL1: begin
          if (in_byte_i == drfr_pkg::ChBang) begin
            phase_d = drfr_pkg::PH_TRAIL2;
          end else begin
            phase_d    = drfr_pkg::PH_HUNT1;
            count_d    = '0;
            res_valid  = 1'b1;
            res_end    = 1'b1;
            res_status = drfr_pkg::StatusBadTrail1;
          end
        end
        drfr_pkg::PH_TRAIL2: begin
          phase_d    = drfr_pkg::PH_HUNT1;
          count_d    = '0;
          res_valid  = 1'b1;
          res_end    = 1'b1;
          res_status = (in_byte_i == drfr_pkg::ChHash) ? drfr_pkg::StatusOk
                                                       : drfr_pkg::StatusBadTrail2;
        end
        default: begin
          // Hunting; unused phase codes hunt as well.
          phase_d = (in_byte_i == drfr_pkg::ChBang) ? drfr_pkg::PH_HUNT2
                                                    : drfr_pkg::PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= drfr_pkg::PH_HUNT1;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with one-entry skid register
  // --------------------------------------------------------------------------
  logic                         out_valid_q, out_valid_d;
  logic [drfr_pkg::DataW-1:0]   out_data_q, out_data_d;
  logic                         out_end_q, out_end_d;
  logic [drfr_pkg::StatusW-1:0] out_status_q, out_status_d;

  logic                         skid_valid_q, skid_valid_d;
  logic [drfr_pkg::DataW-1:0]   skid_data_q, skid_data_d;
  logic                         skid_end_q, skid_end_d;
  logic [drfr_pkg::StatusW-1:0] skid_status_q, skid_status_d;

  logic out_fire;

  // Hold the input off only while the skid register is occupied.
  assign in_ready_o = !skid_valid_q;
  assign out_fire   = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d   = out_valid_q;
    out_data_d    = out_data_q;
    out_end_d     = out_end_q;
    out_status_d  = out_status_q;
    skid_valid_d  = skid_valid_q;
    skid_data_d   = skid_data_q;
    skid_end_d    = skid_end_q;
    skid_status_d = skid_status_q;
    if (skid_valid_q) begin
      // No new request can arrive; advance the skid entry when drained.
      if (out_fire) begin
        out_data_d   = skid_data_q;
        out_end_d    = skid_end_q;
        out_status_d = skid_status_q;
        skid_valid_d = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || out_fire) begin
        out_valid_d  = 1'b1;
        out_data_d   = res_data;
        out_end_d    = res_end;
        out_status_d = res_status;
      end else begin
        skid_valid_d  = 1'b1;
        skid_data_d   = res_data;
        skid_end_d    = res_end;
        skid_status_d = res_status;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q    <= out_data_d;
    out_end_q     <= out_end_d;
    out_status_q  <= out_status_d;
    skid_data_q   <= skid_data_d;
    skid_end_q    <= skid_end_d;
    skid_status_q <= skid_status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign is_end_o       = out_end_q;
  assign frame_status_o = out_status_q;

endmodule
`default_nettype wire

@@ hw/rtl/drfr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// drfr_checker
// Port-level checks of the delimited frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module drfr_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_ready_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [drfr_pkg::DataW-1:0]        out_data_o,
  input wire logic                              is_end_o,
  input wire logic [drfr_pkg::StatusW-1:0]      frame_status_o,
  input wire logic                              psel,
  input wire logic                              penable,
  input wire logic                              pwrite,
  input wire logic [drfr_pkg::ApbAddrW-1:0]     paddr,
  input wire logic [drfr_pkg::ApbDataW-1:0]     pwdata,
  input wire logic [drfr_pkg::ApbDataW-1:0]     prdata,
  input wire logic                              pready
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_data_o) && $stable(is_end_o) && $stable(frame_status_o))
    else $error("result changed while stalled");

  // The input is held off only while a result waits at the output.
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // Payload results always carry ok status.
  a_payload_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_end_o |-> frame_status_o == drfr_pkg::StatusOk)
    else $error("payload result with non-ok status");

  // End results carry zero data and a defined status code.
  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_end_o |->
      out_data_o == '0 && frame_status_o <= drfr_pkg::StatusBadTrail2)
    else $error("malformed end result");

  // A write to the length register reads back in the next cycle.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr == '0
      ##1 paddr == '0 && !(psel && penable && pwrite)
      |-> prdata[drfr_pkg::LenW-1:0] == $past(pwdata[drfr_pkg::LenW-1:0]))
    else $error("length register readback mismatch");

endmodule

bind delimited_frame_receiver drfr_checker u_drfr_checker (.*);
`default_nettype wire
